// ----- rtl/htsm_pkg.sv -----
// Shared types, constants and the saturation curve table for the high-pass tanh saturator.
package htsm_pkg;

   // Fixed field widths of the sample path.
   localparam int SAMPLE_BITS      = 24;
   localparam int FRAC_BITS        = SAMPLE_BITS - 1;
   localparam int CHANNELS_DEFAULT = 2;

   // Curve table geometry.
   localparam int TANH_ENTRIES = 256;
   localparam int TANH_LOG2    = 8;
   localparam int SHAPER_BITS  = SAMPLE_BITS;
   localparam int TIDX_W       = TANH_LOG2 + 1;

   // Register widths and fractional position of the filter coefficients.
   localparam int B0_W      = 31;
   localparam int A1_W      = 32;
   localparam int A2_W      = 30;
   localparam int GAIN_W    = 16;
   localparam int MIX_W     = 17;
   localparam int COEF_FRAC = 30;
   localparam int Y_W       = 32;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes.
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HP_B0      = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HP_A1      = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HP_A2      = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DRIVE_GAIN = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WET_MIX    = 3'd4;

   // Register reset values.
   localparam logic [B0_W-1:0]          HP_B0_RESET      = 31'd1061881272;
   localparam logic signed [A1_W-1:0]   HP_A1_RESET      = -32'sd2123631548;
   localparam logic [A2_W-1:0]          HP_A2_RESET      = 30'd1050151717;
   localparam logic [GAIN_W-1:0]        DRIVE_GAIN_RESET = 16'd19661;
   localparam logic [MIX_W-1:0]         WET_MIX_RESET    = 17'd39322;
   localparam logic [MIX_W-1:0]         MIX_ONE          = 17'd65536;

   // Full-scale output codes.
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_POS_FULL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG_FULL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Shared multiplier operand selection.
   typedef logic [2:0] mul_sel_type;
   localparam mul_sel_type MUL_IDLE   = 3'd0;
   localparam mul_sel_type MUL_B0_D   = 3'd1;
   localparam mul_sel_type MUL_A1_Y1  = 3'd2;
   localparam mul_sel_type MUL_A2_Y2  = 3'd3;
   localparam mul_sel_type MUL_Y_GAIN = 3'd4;
   localparam mul_sel_type MUL_DIFF_F = 3'd5;
   localparam mul_sel_type MUL_X_DRY  = 3'd6;
   localparam mul_sel_type MUL_WET_M  = 3'd7;

   // Accumulator operations.
   typedef logic [1:0] acc_op_type;
   localparam acc_op_type ACC_HOLD = 2'd0;
   localparam acc_op_type ACC_LOAD = 2'd1;
   localparam acc_op_type ACC_ADD  = 2'd2;
   localparam acc_op_type ACC_SUB  = 2'd3;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        filt_en;
      logic        idx_en;
      logic        wet_en;
      logic        out_load;
   } htsm_cmd_type;

   typedef logic [SHAPER_BITS-1:0] shaper_table_type [TANH_ENTRIES+1];

   localparam logic [63:0] Q30 = 64'd1 << 30;

   // Elaboration-time long division used only to build the curve table.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(32*w) in Q30 with w in Q30: series for exp, six squarings, then the ratio.
   function automatic logic [63:0] tanh_q30(input logic [63:0] w);
      logic [63:0] t;
      logic [63:0] e;
      t = Q30;
      for (int k = 7; k >= 1; k--) begin
         t = Q30 - udiv64(w * t, 64'(k) << 30);
      end
      e = t;
      for (int n = 0; n < 6; n++) begin
         e = (e * e + (64'd1 << 29)) >> 30;
      end
      return udiv64((Q30 - e) << 30, Q30 + e);
   endfunction

   // Curve table: tanh(5.6*i/TANH_ENTRIES)/tanh(0.7) in Q.FRAC_BITS.
   function automatic shaper_table_type build_shaper();
      shaper_table_type tab;
      logic [63:0]      norm;
      logic [63:0]      w;
      logic [63:0]      th;
      norm = tanh_q30(udiv64(64'd7 << 24, 64'd5));
      for (int i = 0; i <= TANH_ENTRIES; i++) begin
         w      = udiv64((64'd7 << 27) * 64'(i), 64'(5 * TANH_ENTRIES));
         th     = tanh_q30(w);
         tab[i] = SHAPER_BITS'(udiv64((th << FRAC_BITS) + (norm >> 1), norm));
      end
      return tab;
   endfunction

   localparam shaper_table_type SHAPER_TABLE = build_shaper();

endpackage

// ----- rtl/htsm_ctrl.sv -----
// Sequencer state machine that steps one sample through the shared datapath.
module htsm_ctrl import htsm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output htsm_cmd_type cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_MUL_B0    = 4'd1;
   localparam logic [3:0] S_MUL_A1    = 4'd2;
   localparam logic [3:0] S_MUL_A2    = 4'd3;
   localparam logic [3:0] S_ACC_A2    = 4'd4;
   localparam logic [3:0] S_FILT      = 4'd5;
   localparam logic [3:0] S_DRIVE     = 4'd6;
   localparam logic [3:0] S_SHAPE_IDX = 4'd7;
   localparam logic [3:0] S_SHAPE_MUL = 4'd8;
   localparam logic [3:0] S_SHAPE_SUM = 4'd9;
   localparam logic [3:0] S_MIX_DRY   = 4'd10;
   localparam logic [3:0] S_MIX_WET   = 4'd11;
   localparam logic [3:0] S_MIX_ACC   = 4'd12;
   localparam logic [3:0] S_OUT       = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state and per-state datapath commands.
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mul_sel   = MUL_IDLE;
      cmd.acc_op    = ACC_HOLD;
      case (state_ff)
         S_IDLE: begin
            // No transfer is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL_B0;
            end
         end
         S_MUL_B0: begin
            cmd.mul_sel = MUL_B0_D;
            state_in    = S_MUL_A1;
         end
         S_MUL_A1: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_A1_Y1;
            state_in    = S_MUL_A2;
         end
         S_MUL_A2: begin
            cmd.acc_op  = ACC_SUB;
            cmd.mul_sel = MUL_A2_Y2;
            state_in    = S_ACC_A2;
         end
         S_ACC_A2: begin
            cmd.acc_op = ACC_SUB;
            state_in   = S_FILT;
         end
         S_FILT: begin
            cmd.filt_en = 1'b1;
            state_in    = S_DRIVE;
         end
         S_DRIVE: begin
            cmd.mul_sel = MUL_Y_GAIN;
            state_in    = S_SHAPE_IDX;
         end
         S_SHAPE_IDX: begin
            cmd.idx_en = 1'b1;
            state_in   = S_SHAPE_MUL;
         end
         S_SHAPE_MUL: begin
            cmd.mul_sel = MUL_DIFF_F;
            state_in    = S_SHAPE_SUM;
         end
         S_SHAPE_SUM: begin
            cmd.wet_en = 1'b1;
            state_in   = S_MIX_DRY;
         end
         S_MIX_DRY: begin
            cmd.mul_sel = MUL_X_DRY;
            state_in    = S_MIX_WET;
         end
         S_MIX_WET: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_WET_M;
            state_in    = S_MIX_ACC;
         end
         S_MIX_ACC: begin
            cmd.acc_op = ACC_ADD;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // Wait here until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid holds until the result transfer completes.
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/htsm_dp.sv -----
// Datapath: configuration registers, channel state, shared multiplier and accumulator.
module htsm_dp import htsm_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  htsm_cmd_type                    cmd,
   input  logic                            csr_wen,
   input  logic [CSR_ADDR_BITS-1:0]        csr_addr,
   input  logic [CSR_DATA_W-1:0]           csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]   req_in_sample,
   input  logic                            req_channel,
   output logic signed [SAMPLE_BITS-1:0]   rsp_out_sample,
   output logic                            rsp_out_channel,
   output logic                            rsp_clipped
);

   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int D_W     = SAMPLE_BITS + 3;
   localparam int MUL_W   = Y_W + 1;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int A_W     = Y_W + GAIN_W;
   localparam int LIM_BIT = FRAC_BITS + 16;
   localparam int IDX_LSB = LIM_BIT - TANH_LOG2;
   localparam int MAG_W   = SHAPER_BITS + 2;

   localparam logic signed [ACC_W-1:0] FILT_HALF = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] MIX_HALF  = ACC_W'(1) << 15;
   localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'($signed({1'b0, {(Y_W-1){1'b1}}}));
   localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'($signed({1'b1, {(Y_W-1){1'b0}}}));
   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'($signed(SAMPLE_POS_FULL));
   localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'($signed(SAMPLE_NEG_FULL));

   // Configuration registers.
   logic [B0_W-1:0]        hp_b0_ff;
   logic signed [A1_W-1:0] hp_a1_ff;
   logic [A2_W-1:0]        hp_a2_ff;
   logic [GAIN_W-1:0]      drive_gain_ff;
   logic [MIX_W-1:0]       wet_mix_ff;

   // Per-channel filter history.
   logic signed [SAMPLE_BITS-1:0] x1_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] x2_ff [CHANNELS];
   logic signed [Y_W-1:0]         y1_ff [CHANNELS];
   logic signed [Y_W-1:0]         y2_ff [CHANNELS];

   // Working registers of the current sample.
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          chan_ff;
   logic [CH_W-1:0]               ch_idx_ff;
   logic signed [D_W-1:0]         d_ff;
   logic [Y_W-1:0]                y_mag_ff;
   logic                          y_neg_ff;
   logic [SHAPER_BITS-1:0]        lo_ff;
   logic signed [SHAPER_BITS:0]   diff_ff;
   logic [15:0]                   frac_ff;
   logic                          top_ff;
   logic signed [MAG_W-1:0]       wet_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_channel_ff;
   logic                          clipped_ff;

   // Combinational intermediates.
   logic [CH_W-1:0]          req_idx;
   logic signed [D_W-1:0]    d_in;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [ACC_W-1:0]  y_round, y_q;
   logic signed [Y_W-1:0]    y_sat;
   logic [A_W-1:0]           drive_a;
   logic [TANH_LOG2-1:0]     tidx;
   logic [SHAPER_BITS-1:0]   tab_lo, tab_hi;
   logic signed [MAG_W-1:0]  step, mag;
   logic [MIX_W-1:0]         wet_w, dry_w;
   logic signed [ACC_W-1:0]  mix_round, mix_q;
   logic signed [SAMPLE_BITS-1:0] out_sat;
   logic                     out_clip;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_b0_ff      <= HP_B0_RESET;
         hp_a1_ff      <= HP_A1_RESET;
         hp_a2_ff      <= HP_A2_RESET;
         drive_gain_ff <= DRIVE_GAIN_RESET;
         wet_mix_ff    <= WET_MIX_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_HP_B0:      hp_b0_ff      <= csr_wdata[B0_W-1:0];
            CSR_HP_A1:      hp_a1_ff      <= $signed(csr_wdata[A1_W-1:0]);
            CSR_HP_A2:      hp_a2_ff      <= csr_wdata[A2_W-1:0];
            CSR_DRIVE_GAIN: drive_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_WET_MIX:    wet_mix_ff    <= csr_wdata[MIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Channel select and the feedforward difference x - 2*x1 + x2.
   assign req_idx = (CHANNELS > 1) ? CH_W'(req_channel) : '0;
   assign d_in    = D_W'(req_in_sample) - (D_W'(x1_ff[req_idx]) <<< 1) + D_W'(x2_ff[req_idx]);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff      <= req_in_sample;
         chan_ff   <= req_channel;
         ch_idx_ff <= req_idx;
         d_ff      <= d_in;
      end
   end

   // Mix weights, with wet fractions above unity treated as unity.
   assign wet_w = (wet_mix_ff > MIX_ONE) ? MIX_ONE : wet_mix_ff;
   assign dry_w = MIX_ONE - wet_w;

   // Shared multiplier operand selection.
   always_comb begin
      case (cmd.mul_sel)
         MUL_B0_D: begin
            mul_a = MUL_W'($signed({1'b0, hp_b0_ff}));
            mul_b = MUL_W'(d_ff);
         end
         MUL_A1_Y1: begin
            mul_a = MUL_W'(hp_a1_ff);
            mul_b = MUL_W'(y1_ff[ch_idx_ff]);
         end
         MUL_A2_Y2: begin
            mul_a = MUL_W'($signed({1'b0, hp_a2_ff}));
            mul_b = MUL_W'(y2_ff[ch_idx_ff]);
         end
         MUL_Y_GAIN: begin
            mul_a = MUL_W'($signed({1'b0, y_mag_ff}));
            mul_b = MUL_W'($signed({1'b0, drive_gain_ff}));
         end
         MUL_DIFF_F: begin
            mul_a = MUL_W'(diff_ff);
            mul_b = MUL_W'($signed({1'b0, frac_ff}));
         end
         MUL_X_DRY: begin
            mul_a = MUL_W'(x_ff);
            mul_b = MUL_W'($signed({1'b0, dry_w}));
         end
         MUL_WET_M: begin
            mul_a = MUL_W'(wet_ff);
            mul_b = MUL_W'($signed({1'b0, wet_w}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Accumulator update.
   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = ACC_W'(prod_ff);
         ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         ACC_SUB:  acc_in = acc_ff - ACC_W'(prod_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
   end

   // Filter output: round off the coefficient fraction and saturate to 32 bits.
   always_comb begin
      y_round = acc_ff + FILT_HALF;
      y_q     = y_round >>> COEF_FRAC;
      if (y_q > Y_MAX) begin
         y_sat = Y_W'(Y_MAX);
      end else if (y_q < Y_MIN) begin
         y_sat = Y_W'(Y_MIN);
      end else begin
         y_sat = Y_W'(y_q);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.filt_en) begin
         y_neg_ff <= y_sat[Y_W-1];
         y_mag_ff <= y_sat[Y_W-1] ? (~y_sat + Y_W'(1)) : y_sat;
      end
   end

   // History shift for the sample's channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else if (cmd.filt_en) begin
         x2_ff[ch_idx_ff] <= x1_ff[ch_idx_ff];
         x1_ff[ch_idx_ff] <= x_ff;
         y2_ff[ch_idx_ff] <= y1_ff[ch_idx_ff];
         y1_ff[ch_idx_ff] <= y_sat;
      end
   end

   // Curve lookup: segment index, interpolation fraction and clamp detection.
   assign drive_a = prod_ff[A_W-1:0];
   assign tidx    = drive_a[LIM_BIT-1:IDX_LSB];
   assign tab_lo  = SHAPER_TABLE[{1'b0, tidx}];
   assign tab_hi  = SHAPER_TABLE[TIDX_W'(tidx) + TIDX_W'(1)];

   always_ff @(posedge clock) begin
      if (cmd.idx_en) begin
         top_ff  <= |drive_a[A_W-1:LIM_BIT];
         lo_ff   <= tab_lo;
         diff_ff <= $signed({1'b0, tab_hi}) - $signed({1'b0, tab_lo});
         frac_ff <= drive_a[IDX_LSB-1:IDX_LSB-16];
      end
   end

   // Interpolated magnitude, clamped beyond the table, with the filter's sign.
   assign step = MAG_W'(prod_ff >>> 16);
   assign mag  = top_ff ? $signed({2'b00, SHAPER_TABLE[TANH_ENTRIES]})
                        : $signed({2'b00, lo_ff}) + step;

   always_ff @(posedge clock) begin
      if (cmd.wet_en) begin
         wet_ff <= y_neg_ff ? -mag : mag;
      end
   end

   // Mix rounding and output saturation.
   always_comb begin
      mix_round = acc_ff + MIX_HALF;
      mix_q     = mix_round >>> 16;
      out_clip  = 1'b0;
      if (mix_q > OUT_MAX) begin
         out_sat  = SAMPLE_POS_FULL;
         out_clip = 1'b1;
      end else if (mix_q < OUT_MIN) begin
         out_sat  = SAMPLE_NEG_FULL;
         out_clip = 1'b1;
      end else begin
         out_sat = SAMPLE_BITS'(mix_q);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_sample_ff  <= out_sat;
         out_channel_ff <= chan_ff;
         clipped_ff     <= out_clip;
      end
   end

   assign rsp_out_sample  = out_sample_ff;
   assign rsp_out_channel = out_channel_ff;
   assign rsp_clipped     = clipped_ff;

endmodule

// ----- rtl/hpf_tanh_saturator_mix.sv -----
// Top level of the high-pass filter, tanh saturator and dry/wet mixer.
//
// Usage:
//   Samples enter on the req_ channel (valid/ready) with their channel number
//   and leave on the rsp_ channel (valid/ready) with the same channel number
//   and a clip flag. Each channel keeps its own biquad history.
//   Coefficients, drive gain and wet fraction are written through csr_wen,
//   csr_addr and csr_wdata while no sample is in flight; a write takes effect
//   at the next clock edge.
// Sequencing:
//   The sequencer steps each sample through a single shared 33x33
//   multiplier: seven products plus the rounding, lookup and saturation
//   steps between them. A new sample is taken only once the previous
//   result has been loaded into the output register.
// Reset:
//   Synchronous reset restores the register defaults, clears all channel
//   history and empties the output register.
// Stalls:
//   A finished result waits in the output register; the next sample is still
//   accepted and processed, and only its final write waits for rsp_ready.
module hpf_tanh_saturator_mix import htsm_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_in_sample,
   input  logic                          req_channel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                          rsp_out_channel,
   output logic                          rsp_clipped,
   input  logic                          csr_wen,
   input  logic [CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   htsm_cmd_type cmd;

   // Sequencer.
   htsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic and state.
   htsm_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_wen         (csr_wen),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_in_sample   (req_in_sample),
      .req_channel     (req_channel),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_out_channel (rsp_out_channel),
      .rsp_clipped     (rsp_clipped)
   );

endmodule

// ----- rtl/htsm_checker.sv -----
// Port-level checks for the high-pass tanh saturator, bound to the top level.
module htsm_checker import htsm_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   input logic                          rsp_clipped
);

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // The block works on one sample at a time.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second sample taken while one is in flight");

   // No result can appear in the cycle after its sample was taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared too early");

   // A clipped result sits at full scale.
   a_clip_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_out_sample == SAMPLE_POS_FULL || rsp_out_sample == SAMPLE_NEG_FULL))
      else $error("clip flag set on a sample below full scale");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_sample)))
      else $error("stalled result changed");

endmodule

bind hpf_tanh_saturator_mix htsm_checker u_htsm_checker (.*);
